>>> rtl/hpp_pkg.sv
// hpp_pkg: shared types and constants for the heater power to PWM converter.
// Used by hpp_div, hpp_ctrl, hpp_datapath and heater_power_to_pwm. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpp_pkg;

  // Widths of the shared divider
  localparam int DIVIDEND_W = 28;
  localparam int DIVISOR_W  = 20;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Multiplier operand and product widths
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 10;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Limits and mode thresholds
  localparam logic [19:0] AVAIL_LIMIT      = 20'd1000000;
  localparam logic [19:0] UNKNOWN_R_POWER  = 20'd100;
  localparam int          MODE_MID         = 128;
  localparam int          MODE_TOL         = 16;
  localparam logic [7:0]  MODE_SLOW_ABOVE  = 8'(MODE_MID + MODE_TOL);
  localparam logic [7:0]  MODE_FAST_BELOW  = 8'(MODE_MID - MODE_TOL);

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_POWER_PWM  = 2'd0;
  localparam logic [1:0] REG_TOTAL_PWM  = 2'd1;
  localparam logic [1:0] REG_TIP_RES    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV_R,
    ST_WAIT_R,
    ST_SCALE,
    ST_DIV_TOTAL,
    ST_WAIT_TOTAL,
    ST_AVAIL,
    ST_DUTY_MUL,
    ST_DIV_AVAIL,
    ST_WAIT_AVAIL,
    ST_DUTY,
    ST_ACT_MUL,
    ST_DIV_PPWM,
    ST_WAIT_PPWM,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_SQ,
    OP_DIV_R,
    OP_MUL_SCALE,
    OP_DIV_TOTAL,
    OP_SET_AVAIL,
    OP_MUL_DUTY,
    OP_DIV_AVAIL,
    OP_SET_DUTY,
    OP_MUL_ACT,
    OP_DIV_PPWM,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } hpp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_room;
  } hpp_status_t;

endpackage
`default_nettype wire

>>> rtl/hpp_div.sv
// hpp_div: restoring divider, one quotient bit per cycle.
// Depends on hpp_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module hpp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [hpp_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [hpp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                done,
  output logic [hpp_pkg::DIVIDEND_W-1:0]      quotient
);
  import hpp_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  take;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quotient[DIVIDEND_W-1]};
    take     = (shifted >= {1'b0, dvs});
    diff     = shifted - {1'b0, dvs};
    rem_next = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DIVIDEND_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

>>> rtl/hpp_ctrl.sv
// hpp_ctrl: sequencer that steps the datapath through one conversion.
// Depends on hpp_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module hpp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire hpp_pkg::hpp_status_t status,
  output hpp_pkg::hpp_cmd_t         cmd
);
  import hpp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.op     = OP_MUL_SQ;
        state_next = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.op     = OP_DIV_R;
        state_next = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        if (status.div_done) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op     = OP_MUL_SCALE;
        state_next = ST_DIV_TOTAL;
      end
      ST_DIV_TOTAL: begin
        cmd.op     = OP_DIV_TOTAL;
        state_next = ST_WAIT_TOTAL;
      end
      ST_WAIT_TOTAL: begin
        if (status.div_done) state_next = ST_AVAIL;
      end
      ST_AVAIL: begin
        cmd.op     = OP_SET_AVAIL;
        state_next = ST_DUTY_MUL;
      end
      ST_DUTY_MUL: begin
        cmd.op     = OP_MUL_DUTY;
        state_next = ST_DIV_AVAIL;
      end
      ST_DIV_AVAIL: begin
        cmd.op     = OP_DIV_AVAIL;
        state_next = ST_WAIT_AVAIL;
      end
      ST_WAIT_AVAIL: begin
        if (status.div_done) state_next = ST_DUTY;
      end
      ST_DUTY: begin
        cmd.op     = OP_SET_DUTY;
        state_next = ST_ACT_MUL;
      end
      ST_ACT_MUL: begin
        cmd.op     = OP_MUL_ACT;
        state_next = ST_DIV_PPWM;
      end
      ST_DIV_PPWM: begin
        cmd.op     = OP_DIV_PPWM;
        state_next = ST_WAIT_PPWM;
      end
      ST_WAIT_PPWM: begin
        if (status.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.op = OP_FINISH;
        if (status.out_room) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/hpp_datapath.sv
// hpp_datapath: operand registers, shared multiplier, shared divider and result register.
// Depends on hpp_pkg and hpp_div.
`timescale 1ns / 1ps
`default_nettype none
module hpp_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hpp_pkg::hpp_cmd_t    cmd,
  output hpp_pkg::hpp_status_t      status,
  input  wire logic [7:0]           power_pwm,
  input  wire logic [7:0]           total_pwm,
  input  wire logic [9:0]           tip_resistance_x10,
  input  wire logic [17:0]          requested_x10_watts,
  input  wire logic [9:0]           supply_x10_volts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                duty_level,
  output logic                      fast_mode,
  output logic [19:0]               available_x10_watts,
  output logic [19:0]               actual_x10_watts
);
  import hpp_pkg::*;

  logic                  positive;
  logic [16:0]           raw;
  logic [9:0]            volts;
  logic [DIVIDEND_W-1:0] prod;
  logic [19:0]           avail;
  logic [7:0]            duty;
  logic                  mode_flag;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    mul_p;

  logic                  div_start;
  logic [DIVISOR_W-1:0]  div_dvs;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quo;

  logic [19:0]           avail_next;
  logic [7:0]            duty_next;
  logic [19:0]           actual_next;
  logic                  mode_next;
  logic                  load_out;

  // Operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_SQ: begin
        mul_a = MUL_A_W'(volts);
        mul_b = volts;
      end
      OP_MUL_SCALE: begin
        mul_a = quo[MUL_A_W-1:0];
        mul_b = MUL_B_W'(power_pwm);
      end
      OP_MUL_DUTY: begin
        mul_a = MUL_A_W'(raw);
        mul_b = MUL_B_W'(power_pwm);
      end
      OP_MUL_ACT: begin
        mul_a = avail;
        mul_b = MUL_B_W'(duty);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Divisor select; every division takes the product register as dividend
  always_comb begin
    div_start = 1'b0;
    div_dvs   = '0;
    unique case (cmd.op)
      OP_DIV_R: begin
        div_start = 1'b1;
        div_dvs   = DIVISOR_W'(tip_resistance_x10);
      end
      OP_DIV_TOTAL: begin
        div_start = 1'b1;
        div_dvs   = DIVISOR_W'(total_pwm);
      end
      OP_DIV_AVAIL: begin
        div_start = 1'b1;
        div_dvs   = avail;
      end
      OP_DIV_PPWM: begin
        div_start = 1'b1;
        div_dvs   = DIVISOR_W'(power_pwm);
      end
      default: ;
    endcase
  end

  hpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Special cases and clamps on the quotient
  always_comb begin
    if (tip_resistance_x10 == '0) begin
      avail_next = UNKNOWN_R_POWER;
    end else if (total_pwm == '0) begin
      avail_next = AVAIL_LIMIT;
    end else if (quo > DIVIDEND_W'(AVAIL_LIMIT)) begin
      avail_next = AVAIL_LIMIT;
    end else begin
      avail_next = quo[19:0];
    end

    if (!positive) begin
      duty_next = '0;
    end else if (avail == '0) begin
      duty_next = power_pwm;
    end else if (quo > DIVIDEND_W'(power_pwm)) begin
      duty_next = power_pwm;
    end else begin
      duty_next = quo[7:0];
    end

    if (power_pwm == '0) begin
      actual_next = '0;
    end else if (quo > DIVIDEND_W'(AVAIL_LIMIT)) begin
      actual_next = AVAIL_LIMIT;
    end else begin
      actual_next = quo[19:0];
    end

    // Hysteresis: drop to slow PWM high up, return to fast PWM low down
    mode_next = mode_flag;
    if (duty > MODE_SLOW_ABOVE && mode_flag) begin
      mode_next = 1'b0;
    end else if (duty < MODE_FAST_BELOW && !mode_flag) begin
      mode_next = 1'b1;
    end
  end

  assign status.div_done = div_done;
  assign status.out_room = !out_valid || out_ready;
  assign load_out        = (cmd.op == OP_FINISH) && status.out_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mode_flag <= 1'b1;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        mode_flag <= mode_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        raw      <= requested_x10_watts[16:0];
        positive <= (requested_x10_watts != '0) && !requested_x10_watts[17];
        volts    <= supply_x10_volts;
      end
      OP_MUL_SQ, OP_MUL_SCALE, OP_MUL_DUTY, OP_MUL_ACT: prod <= mul_p[DIVIDEND_W-1:0];
      OP_SET_AVAIL: avail <= avail_next;
      OP_SET_DUTY:  duty  <= duty_next;
      default: ;
    endcase
    if (load_out) begin
      duty_level          <= duty;
      fast_mode           <= mode_next;
      available_x10_watts <= avail;
      actual_x10_watts    <= actual_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/heater_power_to_pwm.sv
// heater_power_to_pwm: top level with the stream ports and the configuration registers.
// Depends on hpp_pkg, hpp_ctrl and hpp_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Converts a requested heater power and a measured supply voltage into a PWM duty
// count. Available power is supply^2 / tip_resistance_x10 * power_pwm / total_pwm,
// saturating at 1000000 (fixed at 100 when the resistance is zero). Duty is
// power_pwm * request / available, clamped at power_pwm; a request of zero or less
// gives duty 0. A fast/slow PWM flag with hysteresis (slow above 144, fast below 112)
// resets to fast. Each item runs four divisions one after another through
// a single restoring divider that retires one quotient bit per cycle over a
// 28-bit dividend, with steps for the shared multiplier and the clamps in
// between. One item is worked on at a time; a new beat is accepted as
// soon as the previous result sits in the output register, even while that result
// still waits for m_tready. Configuration registers sit at byte addresses 0, 4 and 8
// and should be written only while the block is idle.
module heater_power_to_pwm (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [17:0] requested_x10_watts, [27:18] supply_x10_volts
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] duty_level, [8] fast_mode,
                                      // [28:9] available_x10_watts, [48:29] actual_x10_watts
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hpp_pkg::*;

  logic [7:0]  power_pwm;
  logic [7:0]  total_pwm;
  logic [9:0]  tip_resistance_x10;
  logic        cfg_wr;

  hpp_cmd_t    cmd;
  hpp_status_t status;

  logic [7:0]  duty_level;
  logic        fast_mode;
  logic [19:0] available_x10_watts;
  logic [19:0] actual_x10_watts;

  // Config writes complete in the access cycle; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_pwm          <= 8'd244;
      total_pwm          <= 8'd255;
      tip_resistance_x10 <= 10'd80;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_POWER_PWM: power_pwm          <= pwdata[7:0];
        REG_TOTAL_PWM: total_pwm          <= pwdata[7:0];
        REG_TIP_RES:   tip_resistance_x10 <= pwdata[9:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POWER_PWM: prdata = {24'd0, power_pwm};
      REG_TOTAL_PWM: prdata = {24'd0, total_pwm};
      REG_TIP_RES:   prdata = {22'd0, tip_resistance_x10};
      default:       prdata = '0;
    endcase
  end

  // Sequencer: accepts a beat in its idle state, then walks the datapath steps
  hpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  assign s_tready = cmd.in_ready;

  hpp_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .power_pwm           (power_pwm),
    .total_pwm           (total_pwm),
    .tip_resistance_x10  (tip_resistance_x10),
    .requested_x10_watts (s_tdata[17:0]),
    .supply_x10_volts    (s_tdata[27:18]),
    .out_valid           (m_tvalid),
    .out_ready           (m_tready),
    .duty_level          (duty_level),
    .fast_mode           (fast_mode),
    .available_x10_watts (available_x10_watts),
    .actual_x10_watts    (actual_x10_watts)
  );

  // Pack the result beat, first field lowest, pad to whole bytes
  assign m_tdata = {7'd0, actual_x10_watts, available_x10_watts, fast_mode, duty_level};

endmodule
`default_nettype wire
